>>> design/med_pkg.sv
// shared types and constants for the mean euclidean distance block
// no dependencies; used by every module under design/
package med_pkg;

    localparam int MAX_DIMENSIONS = 1024;
    localparam int MAX_VECTORS    = 65536;
    localparam int DIM_W          = $clog2(MAX_DIMENSIONS + 1);
    localparam int CNT_W          = $clog2(MAX_VECTORS + 1);
    localparam int COORD_W        = 24;
    localparam int MAG_W          = 24;
    localparam int SQ_W           = 2 * MAG_W;
    localparam int SUM_W          = 64;
    localparam int VAL_W          = 30;
    localparam int ROOT_W         = SUM_W / 2;
    localparam int QDEPTH         = 2;
    localparam int QPTR_W         = $clog2(QDEPTH);
    localparam int QCNT_W         = $clog2(QDEPTH + 1);

    localparam logic [VAL_W-1:0] VALUE_MAX = {VAL_W{1'b1}};
    localparam logic [CNT_W-1:0] VEC_LIMIT = CNT_W'(MAX_VECTORS);
    localparam logic [DIM_W-1:0] DIM_LIMIT = DIM_W'(MAX_DIMENSIONS);

    localparam logic KIND_DIST = 1'b0;
    localparam logic KIND_MEAN = 1'b1;

    // one finished vector handed from front to back
    typedef struct packed {
        logic [SUM_W-1:0] square_sum;
        logic             vector_sat;
        logic             set_end;
    } med_job_t;

endpackage

>>> design/med_front.sv
// front part: takes coordinate transfers, squares differences, accumulates per vector
// depends on med_pkg
module med_front
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic signed [med_pkg::COORD_W-1:0] member_coord,
    input  logic signed [med_pkg::COORD_W-1:0] center_coord,
    input  logic                            last_of_vector,
    input  logic                            last_of_set,
    output logic                            job_valid,
    input  logic                            job_ready,
    output med_pkg::med_job_t               job
);

    logic                        s1_valid_reg, s1_valid_next;
    logic [med_pkg::MAG_W-1:0]   s1_mag_reg;
    logic                        s1_vend_reg, s1_send_reg;
    logic                        s2_valid_reg, s2_valid_next;
    logic [med_pkg::SQ_W-1:0]    s2_sq_reg;
    logic                        s2_vend_reg, s2_send_reg;
    logic [med_pkg::SUM_W-1:0]   sum_reg, sum_next;
    logic [med_pkg::DIM_W-1:0]   dim_reg, dim_next;
    logic                        vsat_reg, vsat_next;

    logic signed [med_pkg::COORD_W:0] diff;
    logic [med_pkg::COORD_W:0]        absd;
    logic                             s2_go, s2_free, s1_move;
    logic [med_pkg::SUM_W:0]          add_full;
    logic [med_pkg::SUM_W-1:0]        acc_sum;
    logic                             acc_sat;

    assign diff = {member_coord[med_pkg::COORD_W-1], member_coord}
                - {center_coord[med_pkg::COORD_W-1], center_coord};
    assign absd = diff[med_pkg::COORD_W] ? (~diff + 1'b1) : diff;

    assign s2_go    = s2_valid_reg && (!s2_vend_reg || job_ready);
    assign s2_free  = !s2_valid_reg || s2_go;
    assign s1_move  = s1_valid_reg && s2_free;
    assign in_ready = !s1_valid_reg || s2_free;

    assign add_full = {1'b0, sum_reg}
                    + {{(med_pkg::SUM_W + 1 - med_pkg::SQ_W){1'b0}}, s2_sq_reg};

    always_comb
    begin
        acc_sum = sum_reg;
        acc_sat = vsat_reg;
        if (dim_reg < med_pkg::DIM_LIMIT)
        begin
            if (add_full[med_pkg::SUM_W])
            begin
                acc_sum = {med_pkg::SUM_W{1'b1}};
                acc_sat = 1'b1;
            end
            else
            begin
                acc_sum = add_full[med_pkg::SUM_W-1:0];
            end
        end
        else
        begin
            acc_sat = 1'b1;
        end
    end

    assign job_valid       = s2_valid_reg && s2_vend_reg;
    assign job.square_sum  = acc_sum;
    assign job.vector_sat  = acc_sat;
    assign job.set_end     = s2_send_reg;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s2_valid_next = s2_valid_reg;
        sum_next      = sum_reg;
        dim_next      = dim_reg;
        vsat_next     = vsat_reg;
        if (s2_go)
            s2_valid_next = 1'b0;
        if (s1_move)
        begin
            s2_valid_next = 1'b1;
            s1_valid_next = 1'b0;
        end
        if (in_valid && in_ready)
            s1_valid_next = 1'b1;
        if (s2_go)
        begin
            if (s2_vend_reg)
            begin
                sum_next  = '0;
                dim_next  = '0;
                vsat_next = 1'b0;
            end
            else
            begin
                sum_next  = acc_sum;
                vsat_next = acc_sat;
                if (dim_reg < med_pkg::DIM_LIMIT)
                    dim_next = dim_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            sum_reg      <= '0;
            dim_reg      <= '0;
            vsat_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            sum_reg      <= sum_next;
            dim_reg      <= dim_next;
            vsat_reg     <= vsat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_mag_reg  <= absd[med_pkg::MAG_W-1:0];
            s1_vend_reg <= last_of_vector || last_of_set;
            s1_send_reg <= last_of_set;
        end
        if (s1_move)
        begin
            s2_sq_reg   <= s1_mag_reg * s1_mag_reg;
            s2_vend_reg <= s1_vend_reg;
            s2_send_reg <= s1_send_reg;
        end
    end

endmodule

>>> design/med_queue.sv
// short job queue between front and back
// depends on med_pkg
module med_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  med_pkg::med_job_t push_job,
    output logic              pop_valid,
    input  logic              pop_ready,
    output med_pkg::med_job_t pop_job
);

    med_pkg::med_job_t           mem_reg [med_pkg::QDEPTH];
    logic [med_pkg::QPTR_W-1:0]  wr_reg, rd_reg;
    logic [med_pkg::QCNT_W-1:0]  cnt_reg, cnt_next;
    logic                        do_push, do_pop;

    assign push_ready = cnt_reg != med_pkg::QCNT_W'(med_pkg::QDEPTH);
    assign pop_valid  = cnt_reg != '0;
    assign pop_job    = mem_reg[rd_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (do_push)
                wr_reg <= (wr_reg == med_pkg::QPTR_W'(med_pkg::QDEPTH - 1)) ? '0 : wr_reg + 1'b1;
            if (do_pop)
                rd_reg <= (rd_reg == med_pkg::QPTR_W'(med_pkg::QDEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_reg] <= push_job;
    end

endmodule

>>> design/med_back.sv
// back part: iterative square root per vector, set sums, iterative mean division
// depends on med_pkg
module med_back
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         job_valid,
    output logic                         job_ready,
    input  med_pkg::med_job_t            job,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [med_pkg::VAL_W-1:0]    out_value,
    output logic                         out_kind,
    output logic                         out_last,
    output logic                         out_sat
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SQRT = 3'd1;
    localparam logic [2:0] ST_DIST = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_MEAN = 3'd4;
    localparam int         RW      = med_pkg::ROOT_W + 2;
    localparam int         DRW     = med_pkg::CNT_W + 1;

    logic [2:0]                  st_reg;
    logic [5:0]                  it_reg;
    logic [med_pkg::SUM_W-1:0]   n_reg;
    logic [RW-1:0]               rem_reg;
    logic [med_pkg::ROOT_W-1:0]  root_reg;
    logic                        jsat_reg, jset_reg;
    logic [med_pkg::SUM_W-1:0]   dsum_reg;
    logic [med_pkg::CNT_W-1:0]   vcnt_reg;
    logic                        seen_reg;
    logic [DRW-1:0]              drem_reg;
    logic [med_pkg::SUM_W-1:0]   q_reg;
    logic                        ov_reg;
    logic [med_pkg::VAL_W-1:0]   oval_reg;
    logic                        okind_reg, olast_reg, osat_reg;

    logic                        out_free;
    logic                        ov_set;
    logic [RW-1:0]               rem_sh, trial;
    logic [DRW-1:0]              drem_sh, dvs;
    logic                        clamp;
    logic [med_pkg::VAL_W-1:0]   dist_val;
    logic                        vsat;
    logic [med_pkg::SUM_W:0]     dadd;
    logic [med_pkg::SUM_W-1:0]   dsum_new;
    logic [med_pkg::CNT_W-1:0]   vcnt_new;
    logic                        seen_new;
    logic                        mclamp;

    assign out_free  = !ov_reg || out_ready;
    assign ov_set    = out_free && (st_reg == ST_DIST || st_reg == ST_MEAN);
    assign job_ready = st_reg == ST_IDLE;

    assign rem_sh  = {rem_reg[RW-3:0], n_reg[med_pkg::SUM_W-1 -: 2]};
    assign trial   = {root_reg, 2'b01};
    assign drem_sh = {drem_reg[DRW-2:0], q_reg[med_pkg::SUM_W-1]};
    assign dvs     = {1'b0, vcnt_reg};

    assign clamp    = root_reg[med_pkg::ROOT_W-1:med_pkg::VAL_W] != '0;
    assign dist_val = clamp ? med_pkg::VALUE_MAX : root_reg[med_pkg::VAL_W-1:0];
    assign vsat     = jsat_reg || clamp;
    assign dadd     = {1'b0, dsum_reg}
                    + {{(med_pkg::SUM_W + 1 - med_pkg::VAL_W){1'b0}}, dist_val};

    always_comb
    begin
        dsum_new = dadd[med_pkg::SUM_W] ? {med_pkg::SUM_W{1'b1}} : dadd[med_pkg::SUM_W-1:0];
        vcnt_new = vcnt_reg;
        seen_new = seen_reg || vsat || dadd[med_pkg::SUM_W];
        if (vcnt_reg < med_pkg::VEC_LIMIT)
            vcnt_new = vcnt_reg + 1'b1;
        else
            seen_new = 1'b1;
    end

    assign mclamp = q_reg[med_pkg::SUM_W-1:med_pkg::VAL_W] != '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= ST_IDLE;
            it_reg   <= '0;
            dsum_reg <= '0;
            vcnt_reg <= '0;
            seen_reg <= 1'b0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            ov_reg <= ov_set || (ov_reg && !out_ready);
            unique case (st_reg)
                ST_IDLE:
                begin
                    if (job_valid)
                    begin
                        st_reg <= ST_SQRT;
                        it_reg <= '0;
                    end
                end
                ST_SQRT:
                begin
                    it_reg <= it_reg + 1'b1;
                    if (it_reg == 6'(med_pkg::ROOT_W - 1))
                        st_reg <= ST_DIST;
                end
                ST_DIST:
                begin
                    if (out_free)
                    begin
                        dsum_reg <= dsum_new;
                        vcnt_reg <= vcnt_new;
                        seen_reg <= seen_new;
                        it_reg   <= '0;
                        st_reg   <= jset_reg ? ST_DIV : ST_IDLE;
                    end
                end
                ST_DIV:
                begin
                    it_reg <= it_reg + 1'b1;
                    if (it_reg == 6'(med_pkg::SUM_W - 1))
                        st_reg <= ST_MEAN;
                end
                ST_MEAN:
                begin
                    if (out_free)
                    begin
                        dsum_reg <= '0;
                        vcnt_reg <= '0;
                        seen_reg <= 1'b0;
                        st_reg   <= ST_IDLE;
                    end
                end
                default:
                    st_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (st_reg)
            ST_IDLE:
            begin
                n_reg    <= job.square_sum;
                jsat_reg <= job.vector_sat;
                jset_reg <= job.set_end;
                rem_reg  <= '0;
                root_reg <= '0;
            end
            ST_SQRT:
            begin
                n_reg <= {n_reg[med_pkg::SUM_W-3:0], 2'b00};
                if (rem_sh >= trial)
                begin
                    rem_reg  <= rem_sh - trial;
                    root_reg <= {root_reg[med_pkg::ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem_sh;
                    root_reg <= {root_reg[med_pkg::ROOT_W-2:0], 1'b0};
                end
            end
            ST_DIST:
            begin
                if (out_free)
                begin
                    oval_reg  <= dist_val;
                    okind_reg <= med_pkg::KIND_DIST;
                    olast_reg <= !jset_reg;
                    osat_reg  <= vsat;
                    q_reg     <= dsum_new;
                    drem_reg  <= '0;
                end
            end
            ST_DIV:
            begin
                if (drem_sh >= dvs)
                begin
                    drem_reg <= drem_sh - dvs;
                    q_reg    <= {q_reg[med_pkg::SUM_W-2:0], 1'b1};
                end
                else
                begin
                    drem_reg <= drem_sh;
                    q_reg    <= {q_reg[med_pkg::SUM_W-2:0], 1'b0};
                end
            end
            ST_MEAN:
            begin
                if (out_free)
                begin
                    oval_reg  <= mclamp ? med_pkg::VALUE_MAX : q_reg[med_pkg::VAL_W-1:0];
                    okind_reg <= med_pkg::KIND_MEAN;
                    olast_reg <= 1'b1;
                    osat_reg  <= seen_reg || mclamp;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid = ov_reg;
    assign out_value = oval_reg;
    assign out_kind  = okind_reg;
    assign out_last  = olast_reg;
    assign out_sat   = osat_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        vcnt_reg <= med_pkg::VEC_LIMIT)
        else $error("vector count above limit");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg == ST_DIV |-> vcnt_reg != '0)
        else $error("division by zero vector count");

    a_mean_last: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg == ST_MEAN && out_free |=> ov_reg && olast_reg && okind_reg == med_pkg::KIND_MEAN)
        else $error("mean result not marked last");

    a_sets_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg == ST_MEAN && out_free |=> vcnt_reg == '0 && dsum_reg == '0 && !seen_reg)
        else $error("set accumulators not cleared");

endmodule

>>> design/mean_euclidean_distance.sv
// top level of the mean euclidean distance block
// depends on med_pkg, med_front, med_queue, med_back
//
// Coordinate transfers are taken at up to one per cycle while not stalled: the front squares the
// difference in a two-stage pipeline and adds it into a saturating 64-bit sum. At each vector end
// the sum goes through a two-entry queue to the back, which takes the job, runs a bit-per-cycle
// square root and then emits the distance. At a set end a restoring division followed by an emit
// step forms the mean. The back handles one vector at a time, so short vectors make the root the
// limiting loop and the input stalls; longer vectors run at the front's rate.
module mean_euclidean_distance
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // member_coord[23:0], center_coord[47:24]
    input  logic        s_axis_tlast,   // last_of_vector
    input  logic        s_axis_tuser,   // last_of_set
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // result_value[29:0], zero pad [31:30]
    output logic        m_axis_tlast,   // last_of_run
    output logic [1:0]  m_axis_tuser    // result_kind[0], saturated[1]
);

    logic                          job_valid, job_ready;
    med_pkg::med_job_t             job;
    logic                          bj_valid, bj_ready;
    med_pkg::med_job_t             bj;
    logic [med_pkg::VAL_W-1:0]     value;

    med_front u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_axis_tvalid),
        .in_ready       (s_axis_tready),
        .member_coord   (s_axis_tdata[23:0]),
        .center_coord   (s_axis_tdata[47:24]),
        .last_of_vector (s_axis_tlast),
        .last_of_set    (s_axis_tuser),
        .job_valid      (job_valid),
        .job_ready      (job_ready),
        .job            (job)
    );

    med_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (job_valid),
        .push_ready (job_ready),
        .push_job   (job),
        .pop_valid  (bj_valid),
        .pop_ready  (bj_ready),
        .pop_job    (bj)
    );

    med_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (bj_valid),
        .job_ready (bj_ready),
        .job       (bj),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_value (value),
        .out_kind  (m_axis_tuser[0]),
        .out_last  (m_axis_tlast),
        .out_sat   (m_axis_tuser[1])
    );

    assign m_axis_tdata = {2'b00, value};

endmodule

>>> tb/sv/tb_mean_euclidean_distance.sv
// testbench for mean_euclidean_distance: directed table, an overlong vector, then random coordinate streams
// depends on med_pkg and the mean_euclidean_distance rtl
`timescale 1ns / 1ps

module tb_mean_euclidean_distance;

    typedef struct packed {
        logic [med_pkg::VAL_W-1:0] value;
        logic                      kind;
        logic                      last;
        logic                      sat;
    } dist_res_t;

    typedef struct {
        logic [23:0]               member;
        logic [23:0]               center;
        logic                      vec_end;
        logic                      set_end;
        logic                      has_exp;
        logic [med_pkg::VAL_W-1:0] exp_dist;
    } coord_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic        s_axis_tlast;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic [1:0]  m_axis_tuser;

    mean_euclidean_distance dut (.*);

    // predictor state
    logic [63:0] sq_acc;
    logic [63:0] dist_acc;
    int unsigned vec_cnt;
    int unsigned dim_cnt;
    logic        set_sat;
    logic        vec_sat;

    dist_res_t   expected_q[$];
    int          errors;
    bit          quiet;
    bit          hold_long;
    bit          long_done;

    initial
    begin
        clk = 1'b0;
    end
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        #200ms;
        $display("TB_ERROR");
        $finish;
    end

    function automatic logic [63:0] isqrt(input logic [63:0] n);
        logic [63:0] r;
        logic [63:0] b;
        r = '0;
        b = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b,
                                            inout logic flag);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s[64])
        begin
            flag = 1'b1;
            return '1;
        end
        return s[63:0];
    endfunction

    task automatic add_expected(input dist_res_t r);
        expected_q.insert(expected_q.size(), r);
    endtask

    task automatic clear_sums();
        sq_acc = '0; dist_acc = '0; vec_cnt = 0; dim_cnt = 0;
        set_sat = 1'b0; vec_sat = 1'b0;
    endtask

    task automatic predict_distance(input logic [23:0] m, input logic [23:0] c,
                                    input logic ve, input logic se);
        logic signed [24:0] d;
        logic [63:0] mag;
        logic [63:0] dist_val;
        logic [63:0] mean;
        dist_res_t   r;
        if (dim_cnt < med_pkg::MAX_DIMENSIONS)
        begin
            d = $signed({m[23], m}) - $signed({c[23], c});
            mag = (d < 0) ? 64'(-d) : 64'(d);
            sq_acc = sat_add(sq_acc, mag * mag, vec_sat);
            dim_cnt++;
        end
        else
            vec_sat = 1'b1;
        if (!(ve || se))
            return;
        dist_val = isqrt(sq_acc);
        if (dist_val > 64'(med_pkg::VALUE_MAX))
        begin
            dist_val = 64'(med_pkg::VALUE_MAX);
            vec_sat = 1'b1;
        end
        dist_acc = sat_add(dist_acc, dist_val, set_sat);
        if (vec_cnt < med_pkg::MAX_VECTORS)
            vec_cnt++;
        else
            set_sat = 1'b1;
        if (vec_sat)
            set_sat = 1'b1;
        r.value = dist_val[med_pkg::VAL_W-1:0];
        r.kind = med_pkg::KIND_DIST;
        r.last = !se;
        r.sat = vec_sat;
        add_expected(r);
        sq_acc = '0; dim_cnt = 0; vec_sat = 1'b0;
        if (se)
        begin
            mean = dist_acc / vec_cnt;
            if (mean > 64'(med_pkg::VALUE_MAX))
            begin
                mean = 64'(med_pkg::VALUE_MAX);
                set_sat = 1'b1;
            end
            r.value = mean[med_pkg::VAL_W-1:0];
            r.kind = med_pkg::KIND_MEAN;
            r.last = 1'b1;
            r.sat = set_sat;
            add_expected(r);
            clear_sums();
        end
    endtask

    task automatic send_coord(input logic [23:0] m, input logic [23:0] c,
                              input logic ve, input logic se);
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 11);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {c, m};
        s_axis_tlast  <= ve;
        s_axis_tuser  <= se;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_distance(m, c, ve, se);
    endtask

    // receiver with random stalls and one long hold-off
    initial
    begin
        int gap;
        m_axis_tready = 1'b0;
        long_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_long && !long_done)
            begin
                m_axis_tready <= 1'b0;
                repeat (400) @(posedge clk);
                long_done = 1'b1;
            end
            else if (!quiet && $urandom_range(0, 4) == 0)
            begin
                gap = $urandom_range(1, 11);
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        dist_res_t got;
        dist_res_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.value = m_axis_tdata[med_pkg::VAL_W-1:0];
            got.kind = m_axis_tuser[0];
            got.last = m_axis_tlast;
            got.sat = m_axis_tuser[1];
            if (expected_q.size() == 0)
            begin
                $display("%0t unexpected result: actual %h", $time, got);
                errors++;
            end
            else
            begin
                want = expected_q.pop_front();
                if (got.value !== want.value || got.kind !== want.kind ||
                    got.last !== want.last || got.sat !== want.sat ||
                    m_axis_tdata[31:30] !== 2'b00)
                begin
                    $display("%0t mismatch: expected %h/%b/%b/%b actual %h/%b/%b/%b",
                             $time, want.value, want.kind, want.last, want.sat,
                             got.value, got.kind, got.last, got.sat);
                    errors++;
                end
            end
        end
    end

    function automatic logic [23:0] rand_coord(input int mode);
        unique case (mode)
            0: return 24'h800000;
            1: return 24'h7FFFFF;
            2: return 24'($urandom_range(0, 8191)) - 24'd4096;
            default: return 24'($urandom);
        endcase
    endfunction

    initial
    begin
        coord_row_t table_rows[$];
        coord_row_t row;
        int n;
        int vlen;
        int cnt;
        int mode;
        logic se;
        dist_res_t peek;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        s_axis_tuser = 1'b0;
        errors = 0; quiet = 1'b0; hold_long = 1'b0;
        clear_sums();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows: member, center, vector end, set end, known distance
        table_rows = '{
            '{24'h000000, 24'h000000, 1'b1, 1'b0, 1'b1, 30'h0},
            '{24'h001000, 24'h000000, 1'b1, 1'b0, 1'b1, 30'h1000},
            '{24'h000000, 24'h003000, 1'b1, 1'b1, 1'b1, 30'h3000},
            '{24'h7FFFFF, 24'h800000, 1'b1, 1'b0, 1'b1, 30'hFFFFFF},
            '{24'h800000, 24'h7FFFFF, 1'b0, 1'b0, 1'b0, 30'h0},
            '{24'h800000, 24'h7FFFFF, 1'b0, 1'b1, 1'b0, 30'h0},
            '{24'h003000, 24'h000000, 1'b0, 1'b0, 1'b0, 30'h0},
            '{24'h000000, 24'h004000, 1'b1, 1'b0, 1'b1, 30'h5000},
            '{24'h123456, 24'hABCDEF, 1'b0, 1'b0, 1'b0, 30'h0},
            '{24'hFFFFFF, 24'h000001, 1'b0, 1'b1, 1'b0, 30'h0},
            '{24'h555555, 24'hAAAAAA, 1'b1, 1'b1, 1'b0, 30'h0}
        };
        foreach (table_rows[i])
        begin
            row = table_rows[i];
            send_coord(row.member, row.center, row.vec_end, row.set_end);
            if (row.has_exp)
            begin
                peek = expected_q[$ - (row.set_end ? 1 : 0)];
                if (peek.value !== row.exp_dist)
                begin
                    $display("%0t table row %0d: expected %h actual prediction %h",
                             $time, i, row.exp_dist, peek.value);
                    errors++;
                end
            end
        end

        // too many coordinates in one vector
        for (int i = 0; i < med_pkg::MAX_DIMENSIONS + 3; i++)
            send_coord(24'h7FFFFF, 24'h800000, 1'b0, i == med_pkg::MAX_DIMENSIONS + 2);

        // sender pause until drained
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);

        // receiver holds off while short vectors pile up
        hold_long = 1'b1;
        n = 0;
        while (n < 760)
        begin
            if (n > 600)
                quiet = 1'b1;
            vlen = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
            cnt = $urandom_range(1, 5);
            mode = $urandom_range(0, 7);
            for (int v = 0; v < cnt; v++)
                for (int k = 0; k < vlen; k++)
                begin
                    se = (v == cnt - 1) && (k == vlen - 1);
                    send_coord(rand_coord(mode), rand_coord($urandom_range(0, 7)),
                               (k == vlen - 1) ? 1'b1 : $urandom_range(0, 20) == 0, se);
                    n++;
                end
        end
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0 && expected_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> files.f
design/med_pkg.sv
design/med_front.sv
design/med_queue.sv
design/med_back.sv
design/mean_euclidean_distance.sv
tb/sv/tb_mean_euclidean_distance.sv
